@@ rtl/ndff_pkg.sv @@
// shared types, constants and helpers for the near-duplicate filtered mark fifo
package ndff_pkg;

    // store geometry
    localparam int FIFO_DEPTH = 64;
    localparam int KIND_COUNT = 16;
    localparam int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // field widths
    localparam int POS_W      = 24;
    localparam int RAD_W      = 20;
    localparam int KIND_W     = 4;
    localparam int REQ_KIND_W = 8;
    localparam int STAT_W     = 2;
    localparam int OCNT_W     = 7;

    // stream widths
    localparam int S_DATA_W   = 80;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = 16;
    localparam int M_USER_W   = 2;

    // config port
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;
    localparam logic [APB_AW-3:0] REG_DEDUP = 1'b0;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_STORED  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EVICTED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_CLEARED = 2'd3;

    // one stored mark
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic        [RAD_W-1:0] radius;
        logic        [KIND_W-1:0] kind;
    } t_mark;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic              start;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } t_scan_ctl;

    // status back from the scan unit
    typedef struct packed {
        logic done;
        logic match;
    } t_scan_sts;

    // slot pointer step with wrap
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] res;
        if (p == ADDR_W'(FIFO_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + 1'b1;
        end
        return res;
    endfunction

endpackage

@@ rtl/ndff_scan.sv @@
// mark store memory and the pipelined near-match scan over the held marks
module ndff_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ndff_pkg::t_scan_ctl       i_ctl,
    input  ndff_pkg::t_mark           i_mark,
    input  logic [ndff_pkg::ADDR_W-1:0] i_oldest,
    input  logic [ndff_pkg::CNT_W-1:0]  i_count,
    output ndff_pkg::t_scan_sts       o_sts
);
    import ndff_pkg::*;

    t_mark mem [FIFO_DEPTH];

    logic              r_busy;
    logic [CNT_W-1:0]  r_left;
    logic [ADDR_W-1:0] r_rd_ptr;
    logic              r_v1;
    logic              r_v2;
    logic              r_match;
    t_mark             r_rd_data;

    logic [POS_W:0]    r_ax;
    logic [POS_W:0]    r_ay;
    logic [RAD_W:0]    r_ar;
    logic              r_keq;

    logic              rd_en;
    logic signed [POS_W:0] dx;
    logic signed [POS_W:0] dy;
    logic signed [RAD_W:0] dr;
    logic              hit;

    assign rd_en = r_busy && (r_left != '0);

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_ctl.wr_addr] <= i_mark;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    // read issue sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_left   <= '0;
            r_rd_ptr <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            if (i_ctl.start) begin
                r_busy   <= 1'b1;
                r_left   <= i_count;
                r_rd_ptr <= i_oldest;
            end else if (rd_en) begin
                r_left   <= r_left - 1'b1;
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end else if (o_sts.done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // stage one: signed differences and magnitudes
    always_comb begin
        dx = {i_mark.x[POS_W-1], i_mark.x} - {r_rd_data.x[POS_W-1], r_rd_data.x};
        dy = {i_mark.y[POS_W-1], i_mark.y} - {r_rd_data.y[POS_W-1], r_rd_data.y};
        dr = {1'b0, i_mark.radius} - {1'b0, r_rd_data.radius};
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_ax  <= dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
            r_ay  <= dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
            r_ar  <= dr[RAD_W] ? (RAD_W+1)'(-dr) : (RAD_W+1)'(dr);
            r_keq <= (r_rd_data.kind == i_mark.kind);
        end
    end

    // stage two: quarter-radius window test, 4*|d| < r
    assign hit = r_keq
              && ({r_ax, 2'b00} < (POS_W+3)'(i_mark.radius))
              && ({r_ay, 2'b00} < (POS_W+3)'(i_mark.radius))
              && ({r_ar, 2'b00} < (RAD_W+3)'(i_mark.radius));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.start) begin
            r_match <= 1'b0;
        end else if (r_v2 && hit) begin
            r_match <= 1'b1;
        end
    end

    assign o_sts.done  = r_busy && (r_left == '0) && !r_v1 && !r_v2 && !i_ctl.start;
    assign o_sts.match = r_match;

    // scan checks
    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sts.done |-> !rd_en && !r_v1 && !r_v2)
        else $error("scan done with reads in flight");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en || r_v1) |-> !i_ctl.wr_en)
        else $error("store written during a scan");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("scan restarted while busy");

endmodule

@@ rtl/near_duplicate_filtered_fifo.sv @@
// top level: request handshake, config register, fifo pointers and result register
// Holds up to 64 marks in a single-port-read memory. A clear request, or an add
// request while filtering is off or the store is empty, skips the scan and is
// committed to the output register from the done state. An add request with
// filtering on scans every held mark through the one memory read port, one mark
// per cycle, through a two-stage compare pipeline, before it is committed. A
// result still waiting on the output register holds back the commit of the next
// item until it is taken. One item is worked on at a time; the next is accepted
// while the previous result still waits on the output register. The store needs
// no clearing pass after reset: only held slots are ever read.
module near_duplicate_filtered_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // req_type
    input  logic [ndff_pkg::S_USER_W-1:0]      s_axis_tuser,
    // loc_x, loc_y, mark_radius, mark_kind, zero pad
    input  logic [ndff_pkg::S_DATA_W-1:0]      s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // status
    output logic [ndff_pkg::M_USER_W-1:0]      m_axis_tuser,
    // stored_count, kind_used, zero pad
    output logic [ndff_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ndff_pkg::APB_AW-1:0]        paddr,
    input  logic [ndff_pkg::APB_DW-1:0]        pwdata,
    output logic [ndff_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);
    import ndff_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    t_mark             r_mark;
    logic              r_clear;
    logic              r_chk;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] r_oldest;
    logic              r_dedup;
    logic              r_m_valid;
    logic [STAT_W-1:0] r_m_status;
    logic [OCNT_W-1:0] r_m_count;
    logic [KIND_W-1:0] r_m_kind;

    logic              accept;
    logic              req_clear;
    logic [REQ_KIND_W-1:0] req_kind;
    logic [KIND_W-1:0] kind_ok;
    logic              want_scan;
    logic              commit;
    logic              dup;
    logic              full;
    logic [CNT_W:0]    tail_sum;
    logic [ADDR_W-1:0] tail_addr;
    logic              cfg_wr;
    t_mark             in_mark;
    t_scan_ctl         scan_ctl;
    t_scan_sts         scan_sts;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                 && (paddr[APB_AW-1:2] == REG_DEDUP);
    assign prdata = (paddr[APB_AW-1:2] == REG_DEDUP) ? APB_DW'(r_dedup) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dedup <= 1'b1;
        end else if (cfg_wr) begin
            r_dedup <= pwdata[0];
        end
    end

    // request decode and kind range check
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign req_clear = s_axis_tuser[0];
    assign req_kind  = s_axis_tdata[2*POS_W+RAD_W +: REQ_KIND_W];
    assign kind_ok   = (!req_kind[REQ_KIND_W-1]
                        && ((REQ_KIND_W-1)'(req_kind[REQ_KIND_W-2:0])
                            < (REQ_KIND_W-1)'(KIND_COUNT)))
                       ? req_kind[KIND_W-1:0] : '0;

    always_comb begin
        in_mark.x      = s_axis_tdata[0 +: POS_W];
        in_mark.y      = s_axis_tdata[POS_W +: POS_W];
        in_mark.radius = s_axis_tdata[2*POS_W +: RAD_W];
        in_mark.kind   = kind_ok;
    end

    assign want_scan = !req_clear && r_dedup && (r_count != '0);
    assign s_axis_tready = (r_state == ST_IDLE);

    // append slot and commit decision
    assign full      = (r_count == CNT_W'(FIFO_DEPTH));
    assign tail_sum  = (CNT_W+1)'(r_oldest) + (CNT_W+1)'(r_count);
    assign tail_addr = (tail_sum >= (CNT_W+1)'(FIFO_DEPTH))
                       ? ADDR_W'(tail_sum - (CNT_W+1)'(FIFO_DEPTH))
                       : ADDR_W'(tail_sum);
    assign commit    = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);
    assign dup       = r_chk && scan_sts.match;

    always_comb begin
        scan_ctl.start   = accept && want_scan;
        scan_ctl.wr_en   = commit && !r_clear && !dup;
        scan_ctl.wr_addr = full ? r_oldest : tail_addr;
    end

    ndff_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (scan_ctl),
        .i_mark   (r_mark),
        .i_oldest (r_oldest),
        .i_count  (r_count),
        .o_sts    (scan_sts)
    );

    // request payload capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mark  <= in_mark;
            r_clear <= req_clear;
            r_chk   <= want_scan;
        end
    end

    // sequencer, fifo pointers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_oldest  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (m_axis_tready && !commit) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= want_scan ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN: begin
                    if (scan_sts.done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (commit) begin
                        r_state   <= ST_IDLE;
                        r_m_valid <= 1'b1;
                        if (r_clear) begin
                            r_count  <= '0;
                            r_oldest <= '0;
                        end else if (!dup) begin
                            if (full) begin
                                r_oldest <= ptr_inc(r_oldest);
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (commit) begin
            if (r_clear) begin
                r_m_status <= STAT_CLEARED;
                r_m_count  <= '0;
                r_m_kind   <= '0;
            end else if (dup) begin
                r_m_status <= STAT_DUP;
                r_m_count  <= OCNT_W'(r_count);
                r_m_kind   <= r_mark.kind;
            end else if (full) begin
                r_m_status <= STAT_EVICTED;
                r_m_count  <= OCNT_W'(r_count);
                r_m_kind   <= r_mark.kind;
            end else begin
                r_m_status <= STAT_STORED;
                r_m_count  <= OCNT_W'(r_count + 1'b1);
                r_m_kind   <= r_mark.kind;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = M_DATA_W'({r_m_kind, r_m_count});

    // sequencer checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("mark count above store depth");

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_sts.done |-> (r_state == ST_SCAN))
        else $error("scan finished outside the scan state");

    a_dup_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && !r_clear && dup) |=> $stable(r_count) && $stable(r_oldest))
        else $error("dropped item changed the fifo pointers");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_clear) |=> (r_count == '0) && (r_oldest == '0))
        else $error("clear left marks held");

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the near-duplicate filtered mark fifo
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ndff_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned SETTLE      = 100;

    // one request as driven on the slave side
    typedef struct {
        logic                  clear;
        logic [POS_W-1:0]      x;
        logic [POS_W-1:0]      y;
        logic [RAD_W-1:0]      r;
        logic [REQ_KIND_W-1:0] kind_req;
    } t_req;

    // one result as seen on the master side
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [OCNT_W-1:0] count;
        logic [KIND_W-1:0] kind;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    // req_type
    logic [S_USER_W-1:0] s_axis_tuser = '0;
    // loc_x, loc_y, mark_radius, mark_kind, zero pad
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // status
    logic [M_USER_W-1:0] m_axis_tuser;
    // stored_count, kind_used, zero pad
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    near_duplicate_filtered_fifo dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req        request_q[$];
    t_result     awaited_results[$];
    t_req        recent_marks[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    // shadow of the mark store and its register
    t_mark       shadow_marks[FIFO_DEPTH];
    int unsigned shadow_head = 0;
    int unsigned shadow_held = 0;
    bit          shadow_dedup = 1'b1;

    // 4*|d| < r, exact
    function automatic bit close_enough(longint d, longint r);
        longint mag;
        mag = (d < 0) ? -d : d;
        return (4 * mag) < r;
    endfunction

    // works out the result of one request and updates the shadow store
    function automatic t_result filter_mark(t_req rq);
        t_result     res;
        logic [KIND_W-1:0] kind;
        bit          hit;
        int unsigned slot;
        longint      nx, ny, nr;
        nx = longint'($signed(rq.x));
        ny = longint'($signed(rq.y));
        nr = longint'({1'b0, rq.r});
        if (rq.clear) begin
            shadow_held = 0;
            shadow_head = 0;
            res.status  = STAT_CLEARED;
            res.kind    = '0;
        end else begin
            kind = (rq.kind_req[REQ_KIND_W-1:KIND_W] == '0) ? rq.kind_req[KIND_W-1:0] : '0;
            hit  = 1'b0;
            if (shadow_dedup) begin
                for (int unsigned k = 0; k < shadow_held; k++) begin
                    slot = (shadow_head + k) % FIFO_DEPTH;
                    if (shadow_marks[slot].kind == kind
                            && close_enough(nx - longint'($signed(shadow_marks[slot].x)), nr)
                            && close_enough(ny - longint'($signed(shadow_marks[slot].y)), nr)
                            && close_enough(nr - longint'({1'b0, shadow_marks[slot].radius}),
                                            nr)) begin
                        hit = 1'b1;
                    end
                end
            end
            if (hit) begin
                res.status = STAT_DUP;
            end else begin
                if (shadow_held >= FIFO_DEPTH) begin
                    slot        = shadow_head;
                    shadow_head = (shadow_head + 1) % FIFO_DEPTH;
                    res.status  = STAT_EVICTED;
                end else begin
                    slot        = (shadow_head + shadow_held) % FIFO_DEPTH;
                    shadow_held = shadow_held + 1;
                    res.status  = STAT_STORED;
                end
                shadow_marks[slot].x      = rq.x;
                shadow_marks[slot].y      = rq.y;
                shadow_marks[slot].radius = rq.r;
                shadow_marks[slot].kind   = kind;
            end
            res.kind = kind;
        end
        res.count = OCNT_W'(shadow_held);
        return res;
    endfunction

    // random request: mostly near copies of recent marks, some noise, rare clears
    function automatic t_req random_request();
        t_req rq;
        t_req src;
        int   q, dx, dy, dr, nr;
        rq.clear    = 1'b0;
        rq.x        = POS_W'($urandom);
        rq.y        = POS_W'($urandom);
        rq.r        = ($urandom_range(0, 1) == 0) ? RAD_W'($urandom)
                                                  : RAD_W'($urandom_range(0, 4095));
        rq.kind_req = ($urandom_range(0, 3) == 0) ? REQ_KIND_W'($urandom)
                                                  : REQ_KIND_W'($urandom_range(0, 15));
        if ($urandom_range(0, 119) == 0) begin
            rq.clear = 1'b1;
        end else if (recent_marks.size() > 0 && $urandom_range(0, 99) < 55) begin
            src = recent_marks[$urandom_range(0, recent_marks.size() - 1)];
            q   = int'(src.r) >> 2;
            dx  = int'($urandom_range(0, 2 * q + 2)) - (q + 1);
            dy  = int'($urandom_range(0, 2 * q + 2)) - (q + 1);
            dr  = int'($urandom_range(0, 2 * q + 2)) - (q + 1);
            nr  = int'(src.r) + dr;
            if (nr < 0) nr = 0;
            if (nr > 1048575) nr = 1048575;
            rq.x = src.x + POS_W'(dx);
            rq.y = src.y + POS_W'(dy);
            rq.r = RAD_W'(nr);
            if ($urandom_range(0, 9) != 0) begin
                rq.kind_req = src.kind_req;
            end
        end
        if (!rq.clear) begin
            recent_marks.insert(recent_marks.size(), rq);
            if (recent_marks.size() > FIFO_DEPTH) begin
                recent_marks.delete(0);
            end
        end
        return rq;
    endfunction

    task automatic queue_add(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [RAD_W-1:0] r, logic [REQ_KIND_W-1:0] k);
        t_req rq;
        rq.clear    = 1'b0;
        rq.x        = x;
        rq.y        = y;
        rq.r        = r;
        rq.kind_req = k;
        request_q.insert(request_q.size(), rq);
    endtask

    task automatic queue_random(int unsigned n);
        t_req rq;
        repeat (n) begin
            rq = random_request();
            request_q.insert(request_q.size(), rq);
        end
    endtask

    // wait until every item is sent and every result is back
    task automatic wait_drained();
        while (request_q.size() != 0 || s_axis_tvalid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(negedge i_clk);
    endtask

    // write the filter enable with noise in the unused bits, then read it back
    task automatic set_dedup(bit en);
        logic [APB_DW-1:0] wdata;
        wdata    = APB_DW'($urandom);
        wdata[0] = en;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_DEDUP, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        shadow_dedup = en;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[0] !== en) begin
            $error("dedup_enable: expected %0d, actual %0d", en, prdata[0]);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // sender: takes pending items, random gaps between them
    int unsigned send_gap = 0;
    bit          send_burst = 1'b0;
    bit          item_taken = 1'b0;
    t_req        next_req;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || item_taken) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (request_q.size() > 0) begin
                next_req = request_q[0];
                request_q.delete(0);
                s_axis_tuser  <= next_req.clear;
                s_axis_tdata  <= {4'b0, next_req.kind_req, next_req.r, next_req.y, next_req.x};
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
                send_gap <= send_burst ? 0 : $urandom_range(0, 10);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls after each result
    int unsigned recv_stall = 0;
    bit          recv_burst = 1'b0;

    always @(negedge i_clk) begin
        if (recv_stall > 0) begin
            m_axis_tready <= 1'b0;
            recv_stall    <= recv_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // accepted items feed the shadow, accepted results are checked
    always @(posedge i_clk) begin
        t_req    got_req;
        t_result exp_res;
        t_result got_res;
        item_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            got_req.clear    = s_axis_tuser[0];
            got_req.x        = s_axis_tdata[POS_W-1:0];
            got_req.y        = s_axis_tdata[2*POS_W-1:POS_W];
            got_req.r        = s_axis_tdata[2*POS_W+RAD_W-1:2*POS_W];
            got_req.kind_req = s_axis_tdata[2*POS_W+RAD_W+REQ_KIND_W-1:2*POS_W+RAD_W];
            exp_res          = filter_mark(got_req);
            awaited_results.insert(awaited_results.size(), exp_res);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            recv_stall     <= recv_burst ? 0 : $urandom_range(0, 10);
            got_res.status = m_axis_tuser[STAT_W-1:0];
            got_res.count  = m_axis_tdata[OCNT_W-1:0];
            got_res.kind   = m_axis_tdata[OCNT_W+KIND_W-1:OCNT_W];
            if (awaited_results.size() == 0) begin
                $error("result with none awaited: status %0d count %0d kind %0d",
                       got_res.status, got_res.count, got_res.kind);
                error_count++;
            end else begin
                exp_res = awaited_results[0];
                awaited_results.delete(0);
                if (got_res.status !== exp_res.status) begin
                    $error("status: expected %0d, actual %0d", exp_res.status, got_res.status);
                    error_count++;
                end
                if (got_res.count !== exp_res.count) begin
                    $error("stored_count: expected %0d, actual %0d",
                           exp_res.count, got_res.count);
                    error_count++;
                end
                if (got_res.kind !== exp_res.kind) begin
                    $error("kind_used: expected %0d, actual %0d", exp_res.kind, got_res.kind);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus phases
    initial begin
        t_req clr;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_dedup(1'b1);
        // near-match boundaries around a mark of radius 4.0
        queue_add(24'd0, 24'd0, 20'd64, 8'd3);
        queue_add(24'd0, 24'd0, 20'd64, 8'd3);
        queue_add(24'd15, 24'd0, 20'd64, 8'd3);
        queue_add(24'd16, 24'd0, 20'd64, 8'd3);
        queue_add(24'd0, -24'sd15, 20'd64, 8'd3);
        queue_add(24'd0, 24'd0, 20'd60, 8'd3);
        queue_add(24'd0, 24'd0, 20'd64, 8'd4);
        // out-of-range kinds fold to kind 0
        queue_add(24'd100, 24'd100, 20'd64, 8'hFF);
        queue_add(24'd100, 24'd100, 20'd64, 8'd16);
        queue_add(24'd100, 24'd100, 20'd64, 8'h80);
        queue_add(24'd100, 24'd100, 20'd64, 8'h7F);
        // zero radius never matches
        queue_add(24'd500, 24'd500, 20'd0, 8'd2);
        queue_add(24'd500, 24'd500, 20'd0, 8'd2);
        // field extremes
        queue_add(24'h7FFFFF, 24'h800000, 20'hFFFFF, 8'd15);
        queue_add(24'h800000, 24'h7FFFFF, 20'hFFFFF, 8'd15);
        queue_add(24'h7FFFFF, 24'h800000, 20'hFFFFF, 8'd15);
        // clear with all other fields set
        clr.clear    = 1'b1;
        clr.x        = '1;
        clr.y        = '1;
        clr.r        = '1;
        clr.kind_req = '1;
        request_q.insert(request_q.size(), clr);
        queue_add(24'd0, 24'd0, 20'd64, 8'd3);
        wait_drained();

        // filtering off: identical marks are both kept
        set_dedup(1'b0);
        queue_add(24'd0, 24'd0, 20'd64, 8'd3);
        queue_add(24'd0, 24'd0, 20'd64, 8'd3);
        queue_random(300);
        wait_drained();

        set_dedup(1'b1);
        queue_random(400);
        wait_drained();

        set_dedup(1'b0);
        queue_random(100);
        wait_drained();

        set_dedup(1'b1);
        queue_random(230);
        wait_drained();

        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ndff_pkg.sv
rtl/ndff_scan.sv
rtl/near_duplicate_filtered_fifo.sv
tb/tb.sv
